### src/tri_cov_pkg.sv
// Shared types and constants for the triangle coverage test.
// Holds the beat structs, field widths and register indexes; depends on nothing.
package tri_cov_pkg;

	localparam int PIX_W        = 11;  // pixel row / column width
	localparam int VERT_W       = 16;  // vertex coordinate width
	localparam int MARGIN_W     = 24;  // edge margin register width
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 24;

	localparam int COORD_FRAC_BITS_DEF  = 4;
	localparam int MARGIN_FRAC_BITS_DEF = 24;

	// about 1e-5 at 24 fraction bits
	localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(168);

	localparam logic [CFG_IDX_W-1:0] REG_VERT1_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VERT1_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VERT2_X     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VERT2_Y     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VERT3_X     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VERT3_Y     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_MARGIN = 3'd6;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_row;
		logic [PIX_W-1:0] pixel_col;
	} pixel_t;

	typedef struct packed {
		logic inside_res;
		logic degenerate;
	} result_t;

endpackage

### src/triangle_coverage_test.sv
// Pipelined point-in-triangle coverage test, one pixel per clock while the output is not stalled.
// Depends on tri_cov_pkg for the beat structs, widths and register indexes.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+------------------------------
//   in      | in  | in_valid / in_stall    | in_data  (pixel_row, pixel_col)
//   out     | out | out_valid / out_stall  | out_data (inside_res, degenerate)
//   cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Six register stages: operand prep, six products, cross terms, sign fold,
// margin product, final compares into the output register. A new beat is
// taken every clock while the output beat is not stalled.
// Reset clears the stage valid bits and loads the register reset values.
// One enable moves the whole pipe; it holds only while the output beat is
// stalled, so in_stall follows out_stall while the output holds a beat.
// cfg_ready is always high; a write to an unused index is dropped.
module triangle_coverage_test #(
	parameter int COORD_FRAC_BITS  = tri_cov_pkg::COORD_FRAC_BITS_DEF,
	parameter int MARGIN_FRAC_BITS = tri_cov_pkg::MARGIN_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  tri_cov_pkg::pixel_t                in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output tri_cov_pkg::result_t               out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tri_cov_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tri_cov_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tri_cov_pkg::*;

	// Datapath widths, all derived from the coordinate and margin formats.
	localparam int EW   = VERT_W + 1;                         // edge vector
	localparam int PXS  = PIX_W + COORD_FRAC_BITS + 1;        // scaled pixel, signed
	localparam int DW   = ((PXS > VERT_W) ? PXS : VERT_W) + 1; // pixel minus vertex
	localparam int PW   = DW + EW;                            // pixel cross products
	localparam int AW   = PW + 1;                             // A, B
	localparam int DETW = 2 * EW + 1;                         // determinant
	localparam int NW   = AW + 1;                             // sign-folded A, B
	localparam int MW   = MARGIN_W + DETW;                    // margin * |D|
	localparam int SW   = ((NW > DETW + 1) ? NW : DETW + 1) + 2; // |D| - (A+B)
	localparam int LW   = ((NW > SW) ? NW : SW) + MARGIN_FRAC_BITS;
	localparam int CW   = ((LW > MW + 1) ? LW : MW + 1) + 1;  // compare width

	// ---------------- configuration registers ----------------
	logic signed [VERT_W-1:0]   vx1_q, vy1_q, vx2_q, vy2_q, vx3_q, vy3_q;
	logic        [MARGIN_W-1:0] margin_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vx1_q    <= '0;
			vy1_q    <= '0;
			vx2_q    <= '0;
			vy2_q    <= '0;
			vx3_q    <= '0;
			vy3_q    <= '0;
			margin_q <= MARGIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_VERT1_X:     vx1_q    <= cfg_data[VERT_W-1:0];
				REG_VERT1_Y:     vy1_q    <= cfg_data[VERT_W-1:0];
				REG_VERT2_X:     vx2_q    <= cfg_data[VERT_W-1:0];
				REG_VERT2_Y:     vy2_q    <= cfg_data[VERT_W-1:0];
				REG_VERT3_X:     vx3_q    <= cfg_data[VERT_W-1:0];
				REG_VERT3_Y:     vy3_q    <= cfg_data[VERT_W-1:0];
				REG_EDGE_MARGIN: margin_q <= cfg_data[MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	// Config must be written only while the pipe is empty (the block does not
	// enforce it), so every stage may read the registers directly.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv;

	assign adv      = !(v_s6 && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// ---------------- stage 1: operands ----------------
	// u = V2 - V1, v = V3 - V1, d = P*2^F - V1
	logic signed [EW-1:0] ux_s1, uy_s1, wx_s1, wy_s1;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [DW-1:0] col_sc, row_sc;

	assign col_sc = DW'(signed'({1'b0, in_data.pixel_col})) <<< COORD_FRAC_BITS;
	assign row_sc = DW'(signed'({1'b0, in_data.pixel_row})) <<< COORD_FRAC_BITS;

	always_ff @(posedge clk) begin
		if (adv) begin
			ux_s1 <= EW'(vx2_q) - EW'(vx1_q);
			uy_s1 <= EW'(vy2_q) - EW'(vy1_q);
			wx_s1 <= EW'(vx3_q) - EW'(vx1_q);
			wy_s1 <= EW'(vy3_q) - EW'(vy1_q);
			dx_s1 <= col_sc - DW'(vx1_q);
			dy_s1 <= row_sc - DW'(vy1_q);
		end
	end

	// ---------------- stage 2: products ----------------
	logic signed [PW-1:0]     dxwy_s2, dywx_s2, dyux_s2, dxuy_s2;
	logic signed [2*EW-1:0]   uxwy_s2, uywx_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			dxwy_s2 <= PW'(dx_s1) * PW'(wy_s1);
			dywx_s2 <= PW'(dy_s1) * PW'(wx_s1);
			dyux_s2 <= PW'(dy_s1) * PW'(ux_s1);
			dxuy_s2 <= PW'(dx_s1) * PW'(uy_s1);
			uxwy_s2 <= (2*EW)'(ux_s1) * (2*EW)'(wy_s1);
			uywx_s2 <= (2*EW)'(uy_s1) * (2*EW)'(wx_s1);
		end
	end

	// ---------------- stage 3: cross terms ----------------
	logic signed [AW-1:0]   a_s3, b_s3;
	logic signed [DETW-1:0] det_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s3   <= AW'(dxwy_s2) - AW'(dywx_s2);
			b_s3   <= AW'(dyux_s2) - AW'(dxuy_s2);
			det_s3 <= DETW'(uxwy_s2) - DETW'(uywx_s2);
		end
	end

	// ---------------- stage 4: fold sign of D ----------------
	logic signed [NW-1:0]   na_s4, nb_s4;
	logic        [DETW-1:0] adet_s4;
	logic                   degen_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			degen_s4 <= (det_s3 == '0);
			if (det_s3 < 0) begin
				na_s4   <= -NW'(a_s3);
				nb_s4   <= -NW'(b_s3);
				adet_s4 <= DETW'(-det_s3);
			end else begin
				na_s4   <= NW'(a_s3);
				nb_s4   <= NW'(b_s3);
				adet_s4 <= DETW'(det_s3);
			end
		end
	end

	// ---------------- stage 5: margin product ----------------
	// m = M * |D|; e = |D| - (A + B) carries the V2-V3 edge
	logic        [MW-1:0]  m_s5;
	logic signed [NW-1:0]  na_s5, nb_s5;
	logic signed [SW-1:0]  e_s5;
	logic                  degen_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s5     <= MW'(margin_q) * MW'(adet_s4);
			na_s5    <= na_s4;
			nb_s5    <= nb_s4;
			e_s5     <= SW'(signed'({1'b0, adet_s4})) - SW'(na_s4) - SW'(nb_s4);
			degen_s5 <= degen_s4;
		end
	end

	// ---------------- stage 6: compares, output register ----------------
	// x*2^F + m > 0 for each of A, B and |D| - (A+B)
	logic signed [CW-1:0] m_ext, c1, c2, c3;
	logic                 pos1, pos2, pos3;
	result_t              res_s6;

	assign m_ext = CW'(signed'({1'b0, m_s5}));
	assign c1    = (CW'(na_s5) <<< MARGIN_FRAC_BITS) + m_ext;
	assign c2    = (CW'(nb_s5) <<< MARGIN_FRAC_BITS) + m_ext;
	assign c3    = (CW'(e_s5)  <<< MARGIN_FRAC_BITS) + m_ext;
	assign pos1  = !c1[CW-1] && (c1 != '0);
	assign pos2  = !c2[CW-1] && (c2 != '0);
	assign pos3  = !c3[CW-1] && (c3 != '0);

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s6.degenerate <= degen_s5;
			res_s6.inside_res <= !degen_s5 && pos1 && pos2 && pos3;
		end
	end

	assign out_valid = v_s6;
	assign out_data  = res_s6;

	// ---------------- assertions ----------------
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted beat did not enter stage 1");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled output beat");

	a_degen_outside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.inside_res && out_data.degenerate))
		else $error("degenerate triangle reported a covered pixel");

	a_hold_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && in_stall) |=> v_s5)
		else $error("stage 5 beat lost during stall");

endmodule

### tb/tri_cov_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the triangle coverage test: watches the pixel, result and register
// write channels, predicts every result beat and compares it field by field.
// Depends on tri_cov_pkg for the beat structs, field widths and register indexes.
module tri_cov_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  tri_cov_pkg::pixel_t                in_data,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  tri_cov_pkg::result_t               out_data,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [tri_cov_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tri_cov_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                 errors,
	output int                                 checked,
	output int                                 pending,
	output int                                 inside_seen,
	output int                                 degen_seen
);
	import tri_cov_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		pixel_t  pix;
		result_t res;
	} coverage_t;

	// shadow of the vertex and margin registers
	longint vx1, vy1, vx2, vy2, vx3, vy3;
	longint margin;

	coverage_t coverage_q[$];

	// Exact barycentric test: everything is scaled by |D| and 2^MARGIN_FRAC_BITS,
	// so the three strict compares become sign tests on wide integers.
	function automatic result_t predict_coverage(input pixel_t pix);
		longint ux, uy, wx, wy, det, dx, dy, a, b, m;
		wide_t c1, c2, c3;
		result_t r;
		r = '0;
		ux = vx2 - vx1;
		uy = vy2 - vy1;
		wx = vx3 - vx1;
		wy = vy3 - vy1;
		det = ux * wy - uy * wx;
		if (det == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		dx = (longint'(pix.pixel_col) << COORD_FRAC_BITS_DEF) - vx1;
		dy = (longint'(pix.pixel_row) << COORD_FRAC_BITS_DEF) - vy1;
		a = dx * wy - dy * wx;
		b = dy * ux - dx * uy;
		// fold the orientation into a and b so |D| is the scale
		if (det < 0) begin
			det = -det;
			a = -a;
			b = -b;
		end
		m = margin * det;
		c1 = (wide_t'(a) <<< MARGIN_FRAC_BITS_DEF) + wide_t'(m);
		c2 = (wide_t'(b) <<< MARGIN_FRAC_BITS_DEF) + wide_t'(m);
		c3 = (wide_t'(det) <<< MARGIN_FRAC_BITS_DEF) + wide_t'(m)
			- (wide_t'(a + b) <<< MARGIN_FRAC_BITS_DEF);
		r.inside_res = (c1 > 0) && (c2 > 0) && (c3 > 0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		coverage_t want;
		coverage_t fresh;
		result_t got;
		int bad;
		if (!arst_n) begin
			vx1 <= 0;
			vy1 <= 0;
			vx2 <= 0;
			vy2 <= 0;
			vx3 <= 0;
			vy3 <= 0;
			margin <= longint'(MARGIN_RESET);
			coverage_q.delete();
			errors <= 0;
			checked <= 0;
			pending <= 0;
			inside_seen <= 0;
			degen_seen <= 0;
		end else begin
			bad = 0;
			if (out_valid && !out_stall) begin
				got = out_data;
				if (coverage_q.size() == 0) begin
					$display("%0t: result beat with nothing expected (inside_res %0b, degenerate %0b)",
						$time, got.inside_res, got.degenerate);
					bad++;
				end else begin
					want = coverage_q.pop_front();
					if (got.inside_res !== want.res.inside_res) begin
						$display("%0t: pixel row %0d col %0d: inside_res expected %0b, got %0b",
							$time, want.pix.pixel_row, want.pix.pixel_col,
							want.res.inside_res, got.inside_res);
						bad++;
					end
					if (got.degenerate !== want.res.degenerate) begin
						$display("%0t: pixel row %0d col %0d: degenerate expected %0b, got %0b",
							$time, want.pix.pixel_row, want.pix.pixel_col,
							want.res.degenerate, got.degenerate);
						bad++;
					end
					checked <= checked + 1;
				end
				inside_seen <= inside_seen + int'(got.inside_res === 1'b1);
				degen_seen <= degen_seen + int'(got.degenerate === 1'b1);
			end
			if (in_valid && !in_stall) begin
				fresh.pix = in_data;
				fresh.res = predict_coverage(in_data);
				coverage_q.push_back(fresh);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_VERT1_X: vx1 <= longint'($signed(cfg_data[VERT_W-1:0]));
					REG_VERT1_Y: vy1 <= longint'($signed(cfg_data[VERT_W-1:0]));
					REG_VERT2_X: vx2 <= longint'($signed(cfg_data[VERT_W-1:0]));
					REG_VERT2_Y: vy2 <= longint'($signed(cfg_data[VERT_W-1:0]));
					REG_VERT3_X: vx3 <= longint'($signed(cfg_data[VERT_W-1:0]));
					REG_VERT3_Y: vy3 <= longint'($signed(cfg_data[VERT_W-1:0]));
					REG_EDGE_MARGIN: margin <= longint'(cfg_data[MARGIN_W-1:0]);
					default: ;
				endcase
			end
			errors <= errors + bad;
			pending <= coverage_q.size();
		end
	end

endmodule

### tb/tb_triangle_coverage_test.sv
`timescale 1ns / 1ps
// Top of the triangle coverage bench: clock, reset, triangle setups and pixel beats
// with idling on both channels; the verdict comes from the checker's counts.
// Depends on tri_cov_pkg, triangle_coverage_test and tri_cov_checker.
module tb_triangle_coverage_test;
	import tri_cov_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;  // no register behind it
	localparam int SETUPS_PER_MIX   = 6;
	localparam int PIXELS_PER_SETUP = 105;
	localparam int DRAIN_GUARD      = 20000;  // cycles before giving up on a drain
	localparam int PIPE_LATENCY     = 6;
	localparam int PIX_MAX          = (1 << PIX_W) - 1;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	pixel_t                in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	result_t               out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int errors, checked, pending, inside_seen, degen_seen;

	int send_idle_pct = 0;  // chance per cycle that the pixel sender sits out
	int stall_pct     = 0;  // chance per cycle that the result side stalls
	int n_sent        = 0;  // pixel beats accepted by the block
	int n_setups      = 0;

	// current triangle, kept so pixels can be aimed at it
	int tri_x[3];
	int tri_y[3];

	triangle_coverage_test dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tri_cov_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.checked     (checked),
		.pending     (pending),
		.inside_seen (inside_seen),
		.degen_seen  (degen_seen)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Result side: stall is drawn fresh every cycle, independent of out_valid,
	// so stalls land on every stage of the pipe.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic int clamp_pix(input int v);
		if (v < 0)
			return 0;
		if (v > PIX_MAX)
			return PIX_MAX;
		return v;
	endfunction

	function automatic int clamp16(input int v);
		if (v < -32768)
			return -32768;
		if (v > 32767)
			return 32767;
		return v;
	endfunction

	// Random pixel coordinate within the span of three vertex coordinates.
	function automatic int span_pixel(input int a, b, c);
		int lo, hi;
		lo = a;
		hi = a;
		if (b < lo) lo = b;
		if (c < lo) lo = c;
		if (b > hi) hi = b;
		if (c > hi) hi = c;
		lo = clamp_pix(lo >>> COORD_FRAC_BITS_DEF);
		hi = clamp_pix((hi + (1 << COORD_FRAC_BITS_DEF) - 1) >>> COORD_FRAC_BITS_DEF);
		return int'($urandom_range(hi, lo));
	endfunction

	// One pixel beat. Idle cycles go in front of it; the payload then holds
	// until the block takes it. in_valid is left high for back-to-back beats.
	task automatic drive_pixel(input int row, input int col);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{pixel_row: PIX_W'(row), pixel_col: PIX_W'(col)};
		do
			@(posedge clk);
		while (in_stall);
		n_sent++;
	endtask

	// One register write beat; cfg_valid stays up for the next write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	// Program a full triangle plus margin. Vertex writes carry junk in the
	// bits above the 16-bit field, and a write to the unused index follows,
	// which must change nothing.
	task automatic load_triangle(input int x1, y1, x2, y2, x3, y3,
		input logic [MARGIN_W-1:0] margin);
		tri_x = '{x1, x2, x3};
		tri_y = '{y1, y2, y3};
		write_reg(REG_VERT1_X, {8'($urandom), 16'(x1)});
		write_reg(REG_VERT1_Y, {8'($urandom), 16'(y1)});
		write_reg(REG_VERT2_X, {8'($urandom), 16'(x2)});
		write_reg(REG_VERT2_Y, {8'($urandom), 16'(y2)});
		write_reg(REG_VERT3_X, {8'($urandom), 16'(x3)});
		write_reg(REG_VERT3_Y, {8'($urandom), 16'(y3)});
		write_reg(REG_EDGE_MARGIN, margin);
		write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		n_setups++;
	endtask

	// Drop in_valid and wait for every outstanding result, then optionally
	// let the pipe run on empty for the given tail.
	task automatic wait_drained(input int tail);
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (checked < n_sent && guard < DRAIN_GUARD) begin
			@(posedge clk);
			guard++;
		end
		repeat (tail) @(posedge clk);
	endtask

	// Pixels on and right next to the small right triangle's edges.
	// Row 0 and column 0 sit on the legs, (5,5) on the hypotenuse,
	// (0,0) on a vertex; the rest are clearly inside or outside.
	task automatic probe_edges();
		drive_pixel(0, 5);
		drive_pixel(5, 5);
		drive_pixel(5, 0);
		drive_pixel(0, 0);
		drive_pixel(3, 3);
		drive_pixel(1, 1);
		drive_pixel(6, 6);
		drive_pixel(PIX_MAX, PIX_MAX);
	endtask

	// Mostly aimed pixels: the bounding box, points along an edge (rounded
	// down to the pixel grid), vertices with a one-pixel jitter; a quarter
	// are uniform noise over the field.
	task automatic pick_pixel(output int row, output int col);
		int sel, i, j, t;
		sel = $urandom_range(99);
		i = $urandom_range(2);
		j = (i + 1 + int'($urandom_range(1))) % 3;
		if (sel < 40) begin
			col = span_pixel(tri_x[0], tri_x[1], tri_x[2]);
			row = span_pixel(tri_y[0], tri_y[1], tri_y[2]);
		end else if (sel < 65) begin
			t = $urandom_range(8);
			col = (tri_x[i] * (8 - t) + tri_x[j] * t) >>> (3 + COORD_FRAC_BITS_DEF);
			row = (tri_y[i] * (8 - t) + tri_y[j] * t) >>> (3 + COORD_FRAC_BITS_DEF);
		end else if (sel < 75) begin
			col = (tri_x[i] >>> COORD_FRAC_BITS_DEF) + int'($urandom_range(2)) - 1;
			row = (tri_y[i] >>> COORD_FRAC_BITS_DEF) + int'($urandom_range(2)) - 1;
		end else begin
			col = $urandom_range(PIX_MAX);
			row = $urandom_range(PIX_MAX);
		end
		row = clamp_pix(row);
		col = clamp_pix(col);
	endtask

	// Half the setups are compact triangles over the pixel field, some exactly
	// on the pixel grid; the rest are anywhere in the 16-bit range or collinear
	// (including coincident vertices).
	task automatic random_setup();
		int kind, cx, cy, r, k, ex, ey, i, frac_mask;
		int vx[3];
		int vy[3];
		logic [MARGIN_W-1:0] margin;
		case ($urandom_range(4))
			0: margin = '0;
			1: margin = MARGIN_RESET;
			2: margin = MARGIN_W'($urandom_range(4095));
			3: margin = '1;
			default: margin = MARGIN_W'($urandom);
		endcase
		kind = $urandom_range(9);
		if (kind < 5) begin
			cx = $urandom_range(PIX_MAX);
			cy = $urandom_range(PIX_MAX);
			case ($urandom_range(2))
				0: r = 4;
				1: r = 40;
				default: r = 400;
			endcase
			frac_mask = ($urandom_range(1) == 1) ? (1 << COORD_FRAC_BITS_DEF) - 1 : 0;
			for (i = 0; i < 3; i++) begin
				vx[i] = (cx + int'($urandom_range(2 * r)) - r) << COORD_FRAC_BITS_DEF;
				vy[i] = (cy + int'($urandom_range(2 * r)) - r) << COORD_FRAC_BITS_DEF;
				vx[i] = clamp16(vx[i] + (int'($urandom) & frac_mask));
				vy[i] = clamp16(vy[i] + (int'($urandom) & frac_mask));
			end
		end else if (kind < 8) begin
			for (i = 0; i < 3; i++) begin
				vx[i] = int'($urandom_range(65535)) - 32768;
				vy[i] = int'($urandom_range(65535)) - 32768;
			end
		end else begin
			vx[0] = int'($urandom_range(32000)) - 16000;
			vy[0] = int'($urandom_range(32000)) - 16000;
			ex = int'($urandom_range(4000)) - 2000;
			ey = int'($urandom_range(4000)) - 2000;
			k = int'($urandom_range(6)) - 3;
			vx[1] = vx[0] + ex;
			vy[1] = vy[0] + ey;
			vx[2] = vx[0] + k * ex;
			vy[2] = vy[0] + k * ey;
		end
		load_triangle(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2], margin);
	endtask

	initial begin : stimulus
		int mix, s, n, row, col;

		// first idling mix: sender mostly busy, result side mostly stalled
		send_idle_pct = 13;
		stall_pct = 76;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset leaves all vertices at zero, so the triangle is degenerate.
		drive_pixel(0, 0);
		drive_pixel(PIX_MAX, PIX_MAX);
		wait_drained(0);

		// Small right triangle on the pixel grid, zero margin: the strict
		// compares must put every edge pixel outside.
		load_triangle(0, 0, 160, 0, 0, 160, '0);
		probe_edges();
		wait_drained(0);

		// Same triangle wound the other way (negative determinant) with the
		// reset margin: edge pixels now fall inside.
		load_triangle(0, 0, 0, 160, 160, 0, MARGIN_RESET);
		probe_edges();
		wait_drained(0);

		// Vertices at the extremes of the 16-bit range and the largest margin;
		// the determinant and cross terms are at their widest here.
		load_triangle(-32768, -32768, 32767, -32768, -32768, 32767, '1);
		drive_pixel(0, 0);
		drive_pixel(PIX_MAX, PIX_MAX);
		drive_pixel(0, PIX_MAX);
		drive_pixel(PIX_MAX, 0);
		wait_drained(0);

		// Collinear but nonzero vertices: degenerate without any zero register.
		load_triangle(16, 16, 32, 32, 64, 64, MARGIN_RESET);
		drive_pixel(1, 1);
		drive_pixel(1023, 1023);
		wait_drained(0);

		// Random part, under three idling mixes in turn.
		for (mix = 0; mix < 3; mix++) begin
			case (mix)
				0: begin
					send_idle_pct = 13;
					stall_pct = 76;
				end
				1: begin
					send_idle_pct = 76;
					stall_pct = 13;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			for (s = 0; s < SETUPS_PER_MIX; s++) begin
				random_setup();
				for (n = 0; n < PIXELS_PER_SETUP; n++) begin
					pick_pixel(row, col);
					drive_pixel(row, col);
				end
				wait_drained(0);
			end
		end

		wait_drained(PIPE_LATENCY + 4);

		$display("Covered %0d pixels over %0d triangle setups and three idling mixes.",
			checked, n_setups);
		$display("%0d pixels came back inside, %0d against a degenerate triangle.",
			inside_seen, degen_seen);
		if (errors == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			if (pending != 0)
				$display("%0d expected results never came out", pending);
			$display("Regression FAIL");
		end
		$finish;
	end

	// Hard stop in case the run hangs; reports how many results were checked.
	initial begin : watchdog
		#3_000_000;
		$display("Timed out at %0t with %0d of %0d results checked", $time, checked, n_sent);
		$display("Regression FAIL");
		$finish;
	end

endmodule
